// ===== rtl/sliding_window_median_assert.svh =====
// ----------------------------------------------------------------------------
// sliding_window_median_assert
// assertion macros used by the median filter rtl
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define SWM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// shared widths, types and reset values of the running median filter
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int WINDOW_MAX_DEF = 64;
  localparam int SAMPLE_W       = 32;
  localparam int MED_W          = 33;
  localparam int CFG_W          = 7;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MED_W-1:0]    med_t;
  typedef logic [CFG_W-1:0]           wsize_t;

  localparam wsize_t WSIZE_RST = wsize_t'(3);

  // per-cycle command broadcast along the cell row
  typedef struct packed {
    logic    en;
    logic    ins;
    logic    first;
    sample_t sample;
  } swm_ctl_t;

endpackage

// ===== rtl/swm_if.sv =====
// ----------------------------------------------------------------------------
// swm_if
// valid/ready channels of the running median filter
// ----------------------------------------------------------------------------
interface swm_in_if import swm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    first;

  modport source (output valid, output sample, output first, input ready);
  modport sink   (input valid, input sample, input first, output ready);
endinterface

interface swm_out_if import swm_pkg::*; ();
  logic valid;
  logic ready;
  med_t median_doubled;

  modport source (output valid, output median_doubled, input ready);
  modport sink   (input valid, input median_doubled, output ready);
endinterface

interface swm_cfg_if import swm_pkg::*; ();
  logic   valid;
  logic   ready;
  wsize_t window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

// ===== rtl/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell
// one slot of the sorted window: holds a sample and its age, and takes
// its next content from itself, a neighbor or the incoming sample
// ----------------------------------------------------------------------------
module swm_cell import swm_pkg::*; #(
  parameter int AGE_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  swm_ctl_t         ctl,
  input  logic [AGE_W-1:0] oldest_age,
  input  logic             del,
  input  logic             del_left,
  input  logic             l_vld,
  input  logic             l_ge,
  input  sample_t          l_val,
  input  logic [AGE_W-1:0] l_age,
  input  logic             r_vld,
  input  logic             r_ge,
  input  sample_t          r_val,
  input  logic [AGE_W-1:0] r_age,
  output logic             vld_o,
  output logic             ge_o,
  output logic             old_o,
  output sample_t          val_o,
  output logic [AGE_W-1:0] age_o
);

  logic             vld_r, vld_nxt;
  sample_t          val_r, val_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;

  logic             own_v, lv, rv, ge, dlo;
  logic             take_s, take_r, take_l;
  logic [AGE_W-1:0] src_age;

  always_comb begin
    own_v  = vld_r && !ctl.first;
    lv     = l_vld && !ctl.first;
    rv     = r_vld && !ctl.first;
    ge     = ctl.ins && !(own_v && (val_r <= ctl.sample));
    dlo    = del_left || del;
    take_s = ctl.ins && ((!ge && r_ge && dlo) || (ge && !l_ge && !del_left));
    take_r = dlo && !r_ge;
    take_l = !del_left && l_ge;

    vld_nxt = own_v;
    val_nxt = val_r;
    src_age = age_r;
    if (take_s) begin
      vld_nxt = 1'b1;
      val_nxt = ctl.sample;
    end else if (take_r) begin
      vld_nxt = rv;
      val_nxt = r_val;
      src_age = r_age;
    end else if (take_l) begin
      vld_nxt = lv;
      val_nxt = l_val;
      src_age = l_age;
    end
    age_nxt = take_s ? '0 : src_age + AGE_W'(ctl.ins);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

  assign vld_o = vld_r;
  assign ge_o  = ge;
  assign old_o = vld_r && (age_r == oldest_age);
  assign val_o = val_r;
  assign age_o = age_r;

endmodule

// ===== rtl/sliding_window_median.sv =====
// ----------------------------------------------------------------------------
// sliding_window_median
// running median over the last window_size samples, kept sorted in a row
// of cells with age tags; result is twice the median (one fraction bit)
//
//   channel  dir  payload                      accepted when
//   in_chan  in   sample[31:0], first          valid && ready
//   out_chan out  median_doubled[32:0]         valid && ready
//   cfg_chan in   window_size[6:0]             valid && ready (always ready)
//
// one item per cycle: insert and oldest-drop happen in the cell row in the
// accept cycle, the median is read from the cells into the output register
// once that register is free. a new item stalls while a median waits for a
// full output register, and after window_size is lowered, trim steps drop
// the surplus entries before the next item. no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "sliding_window_median_assert.svh"

module sliding_window_median import swm_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input logic       clk,
  input logic       rst_n,
  swm_in_if.sink    in_chan,
  swm_out_if.source out_chan,
  swm_cfg_if.sink   cfg_chan
);

  localparam int AGE_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FILL_W = $clog2(WINDOW_MAX + 1);

  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [FILL_W:0]   fillx_t;
  typedef logic [AGE_W-1:0]  age_t;

  wsize_t   window_size_r;
  fill_t    fill_r, fill_nxt;
  logic     pend_r, pend_nxt;
  logic     med_req_r, med_req_nxt;
  logic     out_vld_r, out_vld_nxt;
  med_t     out_med_r;

  fill_t    k_eff, idx_a, idx_b, fill_base, fill_step;
  logic     slot_free, serve, trim_need, in_fire, del_en;
  age_t     oldest_age;
  swm_ctl_t ctl;
  sample_t  med_a, med_b;

  logic                  vld_p [WINDOW_MAX+2];
  logic                  ge_p  [WINDOW_MAX+2];
  sample_t               val_p [WINDOW_MAX+2];
  age_t                  age_p [WINDOW_MAX+2];
  logic [WINDOW_MAX-1:0] old_vec, del_vec, dl_vec, vld_vec;

  // configuration
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WSIZE_RST;
    end else if (cfg_chan.valid) begin
      window_size_r <= cfg_chan.window_size;
    end
  end

  always_comb begin
    if (window_size_r == '0) begin
      k_eff = fill_t'(1);
    end else if (int'(window_size_r) > WINDOW_MAX) begin
      k_eff = fill_t'(WINDOW_MAX);
    end else begin
      k_eff = fill_t'(window_size_r);
    end
  end

  // control
  assign slot_free = !out_vld_r || out_chan.ready;
  assign serve     = med_req_r && slot_free;
  assign trim_need = !med_req_r && ({1'b0, fill_r} >= ({1'b0, k_eff} + fillx_t'(pend_r)));
  assign in_chan.ready = !trim_need && (!med_req_r || slot_free);
  assign in_fire   = in_chan.valid && in_chan.ready;
  assign del_en    = trim_need || (in_fire && pend_r && !in_chan.first);
  assign oldest_age = age_t'(fill_r - fill_t'(1));

  always_comb begin
    ctl.en     = in_fire || trim_need;
    ctl.ins    = in_fire;
    ctl.first  = in_fire && in_chan.first;
    ctl.sample = in_chan.sample;
  end

  assign fill_base = in_chan.first ? '0 : fill_r - fill_t'(del_en);
  assign fill_step = fill_base + fill_t'(1);

  always_comb begin
    fill_nxt    = fill_r;
    pend_nxt    = pend_r;
    med_req_nxt = serve ? 1'b0 : med_req_r;
    if (in_fire) begin
      fill_nxt    = fill_step;
      pend_nxt    = (fill_step == k_eff);
      med_req_nxt = (fill_step == k_eff);
    end else if (trim_need) begin
      fill_nxt = fill_r - fill_t'(1);
      pend_nxt = 1'b0;
    end
    out_vld_nxt = serve ? 1'b1 : (out_chan.ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      pend_r    <= 1'b0;
      med_req_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      fill_r    <= fill_nxt;
      pend_r    <= pend_nxt;
      med_req_r <= med_req_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // cell row
  assign vld_p[0]            = 1'b0;
  assign ge_p[0]             = 1'b0;
  assign val_p[0]            = '0;
  assign age_p[0]            = '0;
  assign vld_p[WINDOW_MAX+1] = 1'b0;
  assign ge_p[WINDOW_MAX+1]  = ctl.ins;
  assign val_p[WINDOW_MAX+1] = '0;
  assign age_p[WINDOW_MAX+1] = '0;

  assign del_vec = del_en ? old_vec : '0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign dl_vec[i] = 1'b0;
    end else begin : g_body
      assign dl_vec[i] = |del_vec[i-1:0];
    end

    assign vld_vec[i] = vld_p[i+1];

    swm_cell #(
      .AGE_W (AGE_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .oldest_age (oldest_age),
      .del        (del_vec[i]),
      .del_left   (dl_vec[i]),
      .l_vld      (vld_p[i]),
      .l_ge       (ge_p[i]),
      .l_val      (val_p[i]),
      .l_age      (age_p[i]),
      .r_vld      (vld_p[i+2]),
      .r_ge       (ge_p[i+2]),
      .r_val      (val_p[i+2]),
      .r_age      (age_p[i+2]),
      .vld_o      (vld_p[i+1]),
      .ge_o       (ge_p[i+1]),
      .old_o      (old_vec[i]),
      .val_o      (val_p[i+1]),
      .age_o      (age_p[i+1])
    );
  end

  // median tap select
  assign idx_a = (k_eff - fill_t'(1)) >> 1;
  assign idx_b = k_eff >> 1;

  always_comb begin
    med_a = '0;
    med_b = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (fill_t'(i) == idx_a) begin
        med_a = val_p[i+1];
      end
      if (fill_t'(i) == idx_b) begin
        med_b = val_p[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (serve) begin
      out_med_r <= med_t'(med_a) + med_t'(med_b);
    end
  end

  assign out_chan.valid          = out_vld_r;
  assign out_chan.median_doubled = out_med_r;

  `SWM_ASSERT_SAME(a_fill_matches_cells, 1'b1, $countones(vld_vec) == int'(fill_r), "fill count differs from valid cells")
  `SWM_ASSERT_SAME(a_oldest_unique, fill_r != '0, $onehot(old_vec), "oldest entry not unique")
  `SWM_ASSERT_SAME(a_median_full_window, med_req_r, (fill_r == k_eff) && pend_r, "median requested on partial window")
  `SWM_ASSERT_NEXT(a_median_loaded, serve, out_vld_r, "served median not in output register")

endmodule

// ===== tb/sliding_window_median_tb.sv =====
// ----------------------------------------------------------------------------
// sliding_window_median_tb
// self-checking bench for the running median filter: a queue-based window
// predicts twice the median of every full window; directed tests cover the
// sample extremes, window size zero, the first flag, ties, window resizing
// and output back-pressure, then randomized phases sweep window sizes from
// zero past the built depth with random idle gaps on both channels
// ----------------------------------------------------------------------------
module sliding_window_median_tb import swm_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_MAX    = WINDOW_MAX_DEF;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 300;
  localparam int IDLE_LIMIT    = 3000;
  localparam int REPORT_MAX    = 100;

  logic clk = 1'b0;
  logic rst_n;

  swm_in_if  in_ch ();
  swm_out_if out_ch ();
  swm_cfg_if cfg_ch ();

  sliding_window_median #(.WINDOW_MAX(WINDOW_MAX)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_chan (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state: window samples oldest first, and the size register
  sample_t window_q[$];
  wsize_t  model_wsize = WSIZE_RST;
  med_t    expected_medians[$];

  int errors          = 0;
  int items_sent      = 0;
  int medians_checked = 0;
  int sizes_tried     = 0;
  int hold_requests   = 0;
  bit tx_steady       = 1'b0;
  bit rx_steady       = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return sample_t'($urandom);
      4, 5:       return sample_t'($urandom_range(0, 16)) - sample_t'(8);
      6: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return '0;
          default: return '1;
        endcase
      end
      7: begin
        if ($urandom_range(0, 1)) return 32'sh7fffffff - sample_t'($urandom_range(0, 3));
        return 32'sh80000000 + sample_t'($urandom_range(0, 3));
      end
      default: return sample_t'($urandom_range(0, 2000)) - sample_t'(1000);
    endcase
  endfunction

  // insert one sample into the model window and queue the median it yields
  function automatic void predict_median(sample_t s, logic first);
    int      k;
    sample_t sorted[$];
    sample_t t;
    int      j;
    longint  acc;
    k = int'(model_wsize);
    if (k < 1) k = 1;
    if (k > WINDOW_MAX) k = WINDOW_MAX;
    if (first) window_q.delete();
    if (window_q.size() >= WINDOW_MAX) void'(window_q.pop_front());
    window_q.insert(window_q.size(), s);
    while (window_q.size() > k) void'(window_q.pop_front());
    if (window_q.size() < k) return;
    sorted = window_q;
    for (int i = 1; i < sorted.size(); i++) begin
      t = sorted[i];
      j = i - 1;
      while (j >= 0 && sorted[j] > t) begin
        sorted[j+1] = sorted[j];
        j--;
      end
      sorted[j+1] = t;
    end
    if (k % 2 == 1) acc = 2 * longint'(sorted[(k-1)/2]);
    else acc = longint'(sorted[k/2-1]) + longint'(sorted[k/2]);
    expected_medians.insert(expected_medians.size(), med_t'(acc));
    void'(window_q.pop_front());
  endfunction

  task automatic send_item(sample_t s, logic first);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    in_ch.first  <= first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_median(s, first);
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (expected_medians.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window_size(wsize_t v);
    wait_for_results();
    cfg_ch.valid       <= 1'b1;
    cfg_ch.window_size <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    model_wsize = v;
    sizes_tried++;
  endtask

  task automatic test_reset_size();
    send_item(32'sd5, 1'b0);
    send_item(-32'sd7, 1'b0);
    send_item(32'sd2, 1'b0);
    send_item(32'sd9, 1'b0);
  endtask

  task automatic test_sample_extremes();
    write_window_size(wsize_t'(1));
    send_item(32'sh7fffffff, 1'b1);
    send_item(32'sh80000000, 1'b0);
    send_item('0, 1'b0);
    send_item('1, 1'b0);
    write_window_size(wsize_t'(2));
    send_item(32'sh7fffffff, 1'b1);
    send_item(32'sh7fffffff, 1'b0);
    send_item(32'sh80000000, 1'b0);
    send_item(32'sh80000000, 1'b0);
  endtask

  task automatic test_size_zero();
    write_window_size('0);
    send_item(-32'sd3, 1'b0);
    send_item(32'sd11, 1'b0);
  endtask

  task automatic test_first_flag();
    write_window_size(wsize_t'(3));
    send_item(32'sd1, 1'b1);
    send_item(32'sd2, 1'b0);
    send_item(32'sd10, 1'b1);
    send_item(32'sd11, 1'b0);
    send_item(32'sd12, 1'b0);
  endtask

  task automatic test_equal_samples();
    write_window_size(wsize_t'(4));
    send_item(32'sd7, 1'b1);
    send_item(32'sd7, 1'b0);
    send_item(32'sd7, 1'b0);
    send_item(32'sd3, 1'b0);
    send_item(32'sd7, 1'b0);
  endtask

  task automatic test_resize();
    write_window_size(wsize_t'(5));
    send_item(32'sd40, 1'b1);
    send_item(-32'sd5, 1'b0);
    send_item(32'sd17, 1'b0);
    send_item(32'sd8, 1'b0);
    // shrink with four entries held
    write_window_size(wsize_t'(2));
    send_item(32'sd21, 1'b0);
    // grow: one entry left, three more needed
    write_window_size(wsize_t'(4));
    send_item(-32'sd9, 1'b0);
    send_item(32'sd30, 1'b0);
    send_item(32'sd2, 1'b0);
  endtask

  task automatic test_output_backpressure();
    write_window_size(wsize_t'(1));
    tx_steady = 1'b1;
    hold_requests++;
    for (int i = 0; i < 16; i++) send_item(pick_sample(), 1'b0);
    tx_steady = 1'b0;
    wait_for_results();
  endtask

  task automatic test_random_windows();
    int     forced[$] = '{64, 127, 0, 65, 1, 2};
    int     sent;
    int     phase;
    int     keff;
    int     n;
    wsize_t wsz;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase < forced.size()) begin
        wsz = wsize_t'(forced[phase]);
      end else begin
        case ($urandom_range(0, 9))
          6, 7:    wsz = wsize_t'($urandom_range(10, 40));
          8:       wsz = wsize_t'($urandom_range(41, 127));
          9:       wsz = '0;
          default: wsz = wsize_t'($urandom_range(1, 9));
        endcase
      end
      write_window_size(wsz);
      keff = (wsz == 0) ? 1 : ((int'(wsz) > WINDOW_MAX) ? WINDOW_MAX : int'(wsz));
      n = 2 * keff + $urandom_range(20, 80);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) send_item(pick_sample(), $urandom_range(0, 29) == 0);
      sent += n;
      phase++;
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // result side ready, with random stalls and requested long holds
  initial begin
    int stall_left;
    int holds_seen;
    stall_left = 0;
    holds_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (rx_steady || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    med_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_medians.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t: unexpected median, expected none, actual %0d", $time,
                     out_ch.median_doubled);
        end else begin
          want = expected_medians.pop_front();
          medians_checked++;
          if (out_ch.median_doubled !== want) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("%0t: median mismatch, expected %0d, actual %0d", $time, want,
                       out_ch.median_doubled);
          end
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.sample       <= '0;
    in_ch.first        <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.window_size <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_size();
    test_sample_extremes();
    test_size_zero();
    test_first_flag();
    test_equal_samples();
    test_resize();
    test_output_backpressure();
    test_random_windows();

    wait_for_results();
    repeat (10) @(posedge clk);
    $display("sent %0d samples over %0d window size settings, checked %0d medians",
             items_sent, sizes_tried, medians_checked);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
